@@ hw/rtl/merge_sort_values_macros.svh @@
// Assertion macros shared by the sorter RTL.
// Used by files that hold concurrent assertions; no other dependencies.
`ifndef MERGE_SORT_VALUES_MACROS_SVH
`define MERGE_SORT_VALUES_MACROS_SVH

// Same-cycle implication, disabled while reset is held.
`define MSV_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("sorter assertion failed");

// Next-cycle implication, disabled while reset is held.
`define MSV_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("sorter assertion failed");

`endif

@@ hw/rtl/msv_pkg.sv @@
// Shared types and constants of the sorting chain.
// No dependencies; imported by the interfaces, the cell and the top level.
`timescale 1ns / 1ps
`default_nettype none

package msv_pkg;

    localparam int VAL_W = 32;

    // One slot of the chain: occupied flag and signed key.
    typedef struct packed {
        logic                    vld;
        logic signed [VAL_W-1:0] key;
    } t_slot;

endpackage

`default_nettype wire

@@ hw/rtl/msv_ifs.sv @@
// Valid/ready channel interfaces of the sorter: input beats and result beats.
// Depends on msv_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface msv_in_if;
    import msv_pkg::*;

    logic                    valid;
    logic                    ready;
    logic signed [VAL_W-1:0] value;
    logic                    last;

    modport source (output valid, output value, output last, input ready);
    modport sink   (input valid, input value, input last, output ready);
endinterface

interface msv_out_if;
    import msv_pkg::*;

    logic                    valid;
    logic                    ready;
    logic signed [VAL_W-1:0] sorted_value;
    logic                    final_res;
    logic                    overflow;

    modport source (output valid, output sorted_value, output final_res, output overflow,
                    input ready);
    modport sink   (input valid, input sorted_value, input final_res, input overflow,
                    output ready);
endinterface

`default_nettype wire

@@ hw/rtl/msv_cell.sv @@
// One cell of the systolic insertion chain: holds one key, keeps the smaller
// of held and incoming key, passes the larger on; on a shift it takes the next cell's slot. Depends on msv_pkg.
`timescale 1ns / 1ps
`default_nettype none

module msv_cell (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire msv_pkg::t_slot i_in,
    input  wire                 i_shift,
    input  wire msv_pkg::t_slot i_nxt,
    output msv_pkg::t_slot      o_slot,
    output msv_pkg::t_slot      o_pass
);
    import msv_pkg::*;

    logic                    r_vld;
    logic signed [VAL_W-1:0] r_key;
    logic                    r_pv;
    logic signed [VAL_W-1:0] r_pk;

    logic                    w_keep_new;

    assign w_keep_new = !r_vld || (i_in.key < r_key);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
            r_pv  <= 1'b0;
        end else if (i_shift) begin
            r_vld <= i_nxt.vld;
            r_pv  <= 1'b0;
        end else begin
            if (i_in.vld) begin
                r_vld <= 1'b1;
            end
            r_pv <= i_in.vld && r_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_shift) begin
            r_key <= i_nxt.key;
        end else if (i_in.vld) begin
            // hold the smaller key, hand the larger one down the chain
            if (w_keep_new) begin
                r_key <= i_in.key;
                r_pk  <= r_key;
            end else begin
                r_pk  <= i_in.key;
            end
        end
    end

    assign o_slot = '{vld: r_vld, key: r_key};
    assign o_pass = '{vld: r_pv, key: r_pk};

endmodule

`default_nettype wire

@@ hw/rtl/merge_sort_values.sv @@
// Top level of the sorter: a chain of insertion cells plus load/drain control.
// Depends on msv_pkg, msv_ifs, msv_cell and merge_sort_values_macros.svh.
//
// Sorts a set of signed 32-bit values into ascending order. Load takes one
// beat per cycle; every value enters the first cell and ripples down a chain
// of CAPACITY cells, one cell per cycle, each cell keeping the smaller key.
// Beats past CAPACITY are dropped and flag overflow on the whole run. After
// the beat marked last, the input stalls while the insertion wave drains
// through the chain, then the run leaves the first cell at one beat per
// cycle while the result side is ready, with the chain shifting toward it,
// final_res on the last beat. The input is ready again once the final
// result beat is taken.
`timescale 1ns / 1ps
`default_nettype none

`include "merge_sort_values_macros.svh"

module merge_sort_values #(
    parameter int CAPACITY = 32
) (
    input  wire       i_clk,
    input  wire       i_rst_n,
    msv_in_if.sink    i_in,
    msv_out_if.source o_out
);
    import msv_pkg::*;

    localparam int CNT_W = $clog2(CAPACITY + 1);

    localparam logic [1:0] S_LOAD  = 2'd0;
    localparam logic [1:0] S_FLUSH = 2'd1;
    localparam logic [1:0] S_DRAIN = 2'd2;

    logic [1:0]       r_state;
    logic [1:0]       n_state;
    logic [CNT_W-1:0] r_cnt;
    logic [CNT_W-1:0] n_cnt;
    logic             r_ovf;
    logic             n_ovf;

    t_slot            w_in   [CAPACITY];
    t_slot            w_slot [CAPACITY];
    t_slot            w_pass [CAPACITY];
    t_slot            w_nxt  [CAPACITY];
    logic [CAPACITY-1:0] w_pv;

    logic w_in_acc;
    logic w_out_acc;
    logic w_room;
    logic w_busy;

    assign w_room    = (r_cnt < CNT_W'(CAPACITY));
    assign i_in.ready = (r_state == S_LOAD);
    assign w_in_acc  = i_in.valid && i_in.ready;
    assign w_out_acc = o_out.valid && o_out.ready;

    genvar g;
    generate
        for (g = 0; g < CAPACITY; g++) begin : g_cell
            if (g == 0) begin : g_head
                assign w_in[g] = '{vld: w_in_acc && w_room, key: i_in.value};
            end else begin : g_body
                assign w_in[g] = w_pass[g-1];
            end
            if (g == CAPACITY - 1) begin : g_tail
                assign w_nxt[g] = '{vld: 1'b0, key: '0};
            end else begin : g_link
                assign w_nxt[g] = w_slot[g+1];
            end
            assign w_pv[g] = w_pass[g].vld;

            msv_cell u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_in    (w_in[g]),
                .i_shift (w_out_acc),
                .i_nxt   (w_nxt[g]),
                .o_slot  (w_slot[g]),
                .o_pass  (w_pass[g])
            );
        end
    endgenerate

    // any key still travelling down the chain
    assign w_busy = |w_pv;

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        n_ovf   = r_ovf;
        case (r_state)
            S_LOAD: begin
                if (w_in_acc) begin
                    if (w_room) begin
                        n_cnt = r_cnt + CNT_W'(1);
                    end else begin
                        n_ovf = 1'b1;
                    end
                    if (i_in.last) begin
                        n_state = S_FLUSH;
                    end
                end
            end
            S_FLUSH: begin
                if (!w_busy) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                if (w_out_acc) begin
                    n_cnt = r_cnt - CNT_W'(1);
                    if (r_cnt == CNT_W'(1)) begin
                        n_state = S_LOAD;
                        n_ovf   = 1'b0;
                    end
                end
            end
            default: begin
                n_state = S_LOAD;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_LOAD;
            r_cnt   <= '0;
            r_ovf   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_ovf   <= n_ovf;
        end
    end

    assign o_out.valid        = (r_state == S_DRAIN);
    assign o_out.sorted_value = w_slot[0].key;
    assign o_out.final_res    = (r_cnt == CNT_W'(1));
    assign o_out.overflow     = r_ovf;

    `MSV_ASSERT_NOW(a_out_nonempty, i_clk, i_rst_n, o_out.valid, r_cnt != '0)
    `MSV_ASSERT_NOW(a_head_matches_cnt, i_clk, i_rst_n, r_state == S_DRAIN,
                    w_slot[0].vld == (r_cnt != '0))
    `MSV_ASSERT_NEXT(a_run_empties, i_clk, i_rst_n,
                     w_out_acc && o_out.final_res,
                     r_state == S_LOAD && !w_slot[0].vld && !r_ovf)
    `MSV_ASSERT_NOW(a_cnt_bound, i_clk, i_rst_n, 1'b1, r_cnt <= CNT_W'(CAPACITY))

endmodule

`default_nettype wire

@@ tb/msv_result_checker.sv @@
`timescale 1ns / 1ps
// Result checker of the sorter: watches the input and result channels, sorts
// each accepted set on its own side and compares every result beat in order.
// Depends on msv_pkg and the channel interfaces in msv_ifs.

module msv_result_checker #(
    parameter int CAPACITY = 32
) (
    input  logic i_clk,
    input  logic i_rst_n,
    msv_in_if    i_in,
    msv_out_if   i_out,
    output int   o_error_count,
    output int   o_pending
);
    import msv_pkg::*;

    typedef struct packed {
        logic signed [VAL_W-1:0] value;
        logic                    final_res;
        logic                    overflow;
    } t_sorted_beat;

    logic signed [VAL_W-1:0] held_values[$];
    bit                      set_dropped = 1'b0;
    t_sorted_beat            sorted_beats[$];
    int                      error_count = 0;

    assign o_error_count = error_count;

    always @(posedge i_clk) begin : watch
        t_sorted_beat            want;
        logic signed [VAL_W-1:0] key;
        int                      j;
        if (!i_rst_n) begin
            held_values.delete();
            set_dropped = 1'b0;
        end else begin
            // Results taken at this edge belong to an earlier set: check them first.
            if (i_out.valid && i_out.ready) begin
                if (sorted_beats.size() == 0) begin
                    if (error_count < 10) begin
                        $display("unexpected result beat: value=%0d final=%0b overflow=%0b",
                                 i_out.sorted_value, i_out.final_res, i_out.overflow);
                    end
                    error_count++;
                end else begin
                    want = sorted_beats.pop_front();
                    if (i_out.sorted_value !== want.value
                            || i_out.final_res !== want.final_res
                            || i_out.overflow !== want.overflow) begin
                        if (error_count < 10) begin
                            $write("result mismatch: expected value=%0d final=%0b overflow=%0b, ",
                                   want.value, want.final_res, want.overflow);
                            $display("got value=%0d final=%0b overflow=%0b",
                                     i_out.sorted_value, i_out.final_res, i_out.overflow);
                        end
                        error_count++;
                    end
                end
            end

            if (i_in.valid && i_in.ready) begin
                // Drop beats once the store is full; the whole run then flags overflow.
                if (held_values.size() < CAPACITY) begin
                    held_values.push_back(i_in.value);
                end else begin
                    set_dropped = 1'b1;
                end
                if (i_in.last) begin
                    // Stable insertion sort, ascending by signed value.
                    for (int i = 1; i < held_values.size(); i++) begin
                        key = held_values[i];
                        j   = i;
                        while (j > 0 && held_values[j-1] > key) begin
                            held_values[j] = held_values[j-1];
                            j--;
                        end
                        held_values[j] = key;
                    end
                    for (int k = 0; k < held_values.size(); k++) begin
                        want.value     = held_values[k];
                        want.final_res = (k == held_values.size() - 1);
                        want.overflow  = set_dropped;
                        sorted_beats.push_back(want);
                    end
                    held_values.delete();
                    set_dropped = 1'b0;
                end
            end
        end
        o_pending <= sorted_beats.size();
    end

endmodule

@@ tb/testbench.sv @@
`timescale 1ns / 1ps
// Top of the sorter testbench: clock, reset, input beats and result back-pressure.
// Depends on msv_pkg, msv_ifs, merge_sort_values and msv_result_checker.

module testbench;
    import msv_pkg::*;

    localparam int CAPACITY = 32;
    localparam logic signed [VAL_W-1:0] VAL_MIN = 32'sh8000_0000;
    localparam logic signed [VAL_W-1:0] VAL_MAX = 32'sh7FFF_FFFF;

    logic clk;
    logic rst_n;
    bit   idle_on = 1'b1;
    int   items_sent = 0;
    int   error_count;
    int   pending;

    msv_in_if  in_ch();
    msv_out_if out_ch();

    merge_sort_values #(
        .CAPACITY(CAPACITY)
    ) dut (
        .i_clk  (clk),
        .i_rst_n(rst_n),
        .i_in   (in_ch),
        .o_out  (out_ch)
    );

    msv_result_checker #(
        .CAPACITY(CAPACITY)
    ) result_check (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in         (in_ch),
        .i_out        (out_ch),
        .o_error_count(error_count),
        .o_pending    (pending)
    );

    initial begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial begin
        #400000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // Result side: stall in random bursts while idling is on.
    initial begin
        out_ch.ready <= 1'b0;
        forever begin
            @(posedge clk);
            if (idle_on && $urandom_range(0, 7) == 0) begin
                out_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 13)) @(posedge clk);
            end
            out_ch.ready <= 1'b1;
        end
    end

    function automatic logic signed [VAL_W-1:0] pick_value();
        case ($urandom_range(0, 5))
            0: return $signed($urandom_range(0, 15)) - 8;
            1: begin
                case ($urandom_range(0, 3))
                    0: return VAL_MIN;
                    1: return VAL_MAX;
                    2: return '0;
                    default: return -1;
                endcase
            end
            default: return $urandom;
        endcase
    endfunction

    task automatic send_beat(input logic signed [VAL_W-1:0] value, input logic last);
        if (idle_on && $urandom_range(0, 3) == 0) begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.value <= value;
        in_ch.last  <= last;
        do @(posedge clk); while (!in_ch.ready);
        items_sent++;
    endtask

    task automatic send_set(input int size);
        for (int k = 0; k < size; k++) begin
            send_beat(pick_value(), k == size - 1);
        end
    endtask

    initial begin
        logic signed [VAL_W-1:0] directed_vals [19];
        bit                      directed_last [19];
        directed_vals = '{VAL_MIN, VAL_MAX,
                          VAL_MAX, VAL_MIN, 0, -1, 1,
                          5, -5, 5, -5, 5, 0,
                          3, 2, 1, 0, -1, -2};
        directed_last = '{1, 1,
                          0, 0, 0, 0, 1,
                          0, 0, 0, 0, 0, 1,
                          0, 0, 0, 0, 0, 1};
        rst_n       <= 1'b0;
        in_ch.valid <= 1'b0;
        in_ch.value <= '0;
        in_ch.last  <= 1'b0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // Single-value sets, extremes, duplicates and a reversed set.
        for (int k = 0; k < 19; k++) begin
            send_beat(directed_vals[k], directed_last[k]);
        end
        // Fill the store exactly, then lose the last beat, then lose several.
        send_set(CAPACITY);
        send_set(CAPACITY + 1);
        send_set(CAPACITY + 5);
        while (items_sent < 170) begin
            if (items_sent >= 140) begin
                idle_on = 1'b0;
            end
            send_set($urandom_range(1, 12));
        end
        in_ch.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        // Hold a while to catch stray result beats.
        repeat (2 * CAPACITY + 8) @(posedge clk);
        if (error_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
